/* hdl/tcw_pkg.sv */
// Shared widths, character codes and stream packing for the text console writer.
// Used by text_console_writer, its port checker and the testbench; no dependencies.
package tcw_pkg;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int POS_W  = 11;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;

    localparam int DEF_COLS = 80;
    localparam int DEF_ROWS = 25;

    // s_tdata: char_code, read_row, read_col; s_tuser: command
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 1;
    // m_tdata: cursor_row, cursor_col, cursor_position, cell_value
    localparam int M_DATA_W = 40;

    localparam logic [CHAR_W-1:0] ATTR       = 8'h07;
    localparam logic [CHAR_W-1:0] CH_NULL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0d;

    localparam logic CMD_PRINT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

endpackage

/* hdl/text_console_writer.sv */
// Text-mode console: cursor logic around a ROWS x COLS character memory.
// Depends on tcw_pkg.
// A print or an out-of-range read puts its result out in the cycle after accept;
// an in-range read first loads the cell into rd_data_reg, then registers its result.
// Throughput: 1 item per cycle for prints while results are taken; an in-range read
// holds off input until its result is registered; a print that scrolls holds it off
// while the memory port walks all cells. Reset: cursor goes to 0,0 and a clearing pass
// writes a blank to every cell, during which no item is accepted.
module text_console_writer #(
    parameter int COLS = tcw_pkg::DEF_COLS,
    parameter int ROWS = tcw_pkg::DEF_ROWS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] char_code, [12:8] read_row, [19:13] read_col, [23:20] zero
    input  logic [tcw_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] command
    input  logic [tcw_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [4:0] cursor_row, [11:5] cursor_col, [22:12] cursor_position,
    // [38:23] cell_value, [39] zero
    output logic [tcw_pkg::M_DATA_W-1:0]  m_tdata
);
    import tcw_pkg::*;

    localparam int CELLS     = ROWS * COLS;
    localparam int AW        = $clog2(CELLS);
    localparam int LAST_BASE = (ROWS - 1) * COLS;

    localparam logic [AW-1:0]    A_COLS      = AW'(COLS);
    localparam logic [AW-1:0]    A_LAST_BASE = AW'(LAST_BASE);
    localparam logic [AW-1:0]    A_LAST_CELL = AW'(CELLS - 1);
    localparam logic [ROW_W-1:0] R_LAST      = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] C_LAST      = COL_W'(COLS - 1);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_SCROLL = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [AW-1:0]     idx_reg, idx_next;

    // delayed write stage of the sweep (copy or blank)
    logic              cp_valid_reg, cp_valid_next;
    logic              cp_blank_reg, cp_blank_next;
    logic [AW-1:0]     cp_addr_reg, cp_addr_next;

    logic              m_valid_reg, m_valid_next;
    logic [ROW_W-1:0]  m_row_reg, m_row_next;
    logic [COL_W-1:0]  m_col_reg, m_col_next;
    logic [POS_W-1:0]  m_pos_reg, m_pos_next;
    logic [CELL_W-1:0] m_cell_reg, m_cell_next;

    logic [CHAR_W-1:0] screen_mem [CELLS];
    logic [CHAR_W-1:0] rd_data_reg;
    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [CHAR_W-1:0] wr_data;

    logic              in_cmd;
    logic [CHAR_W-1:0] in_char;
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    logic              accept, in_range;
    logic [AW-1:0]     line_base, rd_lin;

    assign in_cmd  = s_tuser[0];
    assign in_char = s_tdata[7:0];
    assign in_row  = s_tdata[12:8];
    assign in_col  = s_tdata[19:13];

    assign s_tready = (state_reg == ST_RUN) && !cp_valid_reg && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign in_range  = (32'(in_row) < ROWS) && (32'(in_col) < COLS);
    assign rd_lin    = AW'(in_row) * A_COLS + AW'(in_col);
    assign line_base = pos_reg - AW'(col_reg);

    always_comb begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        cp_valid_next = 1'b0;
        cp_blank_next = cp_blank_reg;
        cp_addr_next  = cp_addr_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_row_next    = m_row_reg;
        m_col_next    = m_col_reg;
        m_pos_next    = m_pos_reg;
        m_cell_next   = m_cell_reg;
        rd_en         = 1'b0;
        rd_addr       = rd_lin;
        wr_en         = 1'b0;
        wr_addr       = pos_reg;
        wr_data       = in_char;

        case (state_reg)
            ST_CLEAR: begin
                cp_valid_next = 1'b1;
                cp_blank_next = 1'b1;
                cp_addr_next  = idx_reg;
                idx_next      = idx_reg + 1'b1;
                if (idx_reg == A_LAST_CELL) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (accept) begin
                    if (in_cmd == CMD_READ) begin
                        if (in_range) begin
                            rd_en      = 1'b1;
                            state_next = ST_READ;
                        end
                    end else if (in_char == CH_RETURN) begin
                        col_next = '0;
                        pos_next = line_base;
                    end else if (in_char != CH_NULL) begin
                        if (in_char != CH_NEWLINE) begin
                            wr_en = 1'b1;
                        end
                        if (in_char != CH_NEWLINE && col_reg != C_LAST) begin
                            col_next = col_reg + 1'b1;
                            pos_next = pos_reg + 1'b1;
                        end else if (row_reg == R_LAST) begin
                            col_next   = '0;
                            pos_next   = A_LAST_BASE;
                            idx_next   = '0;
                            state_next = ST_SCROLL;
                        end else begin
                            row_next = row_reg + 1'b1;
                            col_next = '0;
                            pos_next = line_base + A_COLS;
                        end
                    end
                    // results of prints depend only on the updated cursor
                    if (!(in_cmd == CMD_READ && in_range)) begin
                        m_valid_next = 1'b1;
                        m_row_next   = row_next;
                        m_col_next   = col_next;
                        m_pos_next   = POS_W'(pos_next);
                        m_cell_next  = '0;
                    end
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                m_row_next   = row_reg;
                m_col_next   = col_reg;
                m_pos_next   = POS_W'(pos_reg);
                m_cell_next  = {ATTR, rd_data_reg};
                state_next   = ST_RUN;
            end
            ST_SCROLL: begin
                // read cell idx+COLS now, write it to idx next cycle; last row gets blanks
                cp_valid_next = 1'b1;
                cp_blank_next = (idx_reg >= A_LAST_BASE);
                cp_addr_next  = idx_reg;
                rd_en         = (idx_reg < A_LAST_BASE);
                rd_addr       = idx_reg + A_COLS;
                idx_next      = idx_reg + 1'b1;
                if (idx_reg == A_LAST_CELL) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase

        if (cp_valid_reg) begin
            wr_en   = 1'b1;
            wr_addr = cp_addr_reg;
            wr_data = cp_blank_reg ? CH_SPACE : rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            screen_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= screen_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            row_reg      <= '0;
            col_reg      <= '0;
            pos_reg      <= '0;
            idx_reg      <= '0;
            cp_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            pos_reg      <= pos_next;
            idx_reg      <= idx_next;
            cp_valid_reg <= cp_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_blank_reg <= cp_blank_next;
        cp_addr_reg  <= cp_addr_next;
        m_row_reg    <= m_row_next;
        m_col_reg    <= m_col_next;
        m_pos_reg    <= m_pos_next;
        m_cell_reg   <= m_cell_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_cell_reg, m_pos_reg, m_col_reg, m_row_reg};

endmodule

/* hdl/tcw_checker.sv */
// Port-level checker for text_console_writer, attached by the bind at the end.
// Depends on tcw_pkg.
module tcw_checker #(
    parameter int COLS = tcw_pkg::DEF_COLS,
    parameter int ROWS = tcw_pkg::DEF_ROWS
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [tcw_pkg::S_DATA_W-1:0]  s_tdata,
    input logic [tcw_pkg::S_USER_W-1:0]  s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tcw_pkg::M_DATA_W-1:0]  m_tdata
);
    import tcw_pkg::*;

    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic [POS_W-1:0] out_pos;
    logic [ROW_W-1:0] req_row;
    logic [COL_W-1:0] req_col;
    logic             req_in_range;

    assign out_row = m_tdata[4:0];
    assign out_col = m_tdata[11:5];
    assign out_pos = m_tdata[22:12];

    assign req_row      = s_tdata[12:8];
    assign req_col      = s_tdata[19:13];
    assign req_in_range = (32'(req_row) < ROWS) && (32'(req_col) < COLS);

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(out_row) < ROWS) && (32'(out_col) < COLS))
        else $error("cursor out of screen");

    a_pos_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_pos == POS_W'(32'(out_row) * COLS + 32'(out_col)))
        else $error("cursor position does not match row and column");

    // an in-range read needs the memory cycle before the next item can enter
    a_read_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == CMD_READ && req_in_range |=> !s_tready)
        else $error("item accepted during a cell read");

endmodule

bind text_console_writer tcw_checker #(.COLS(COLS), .ROWS(ROWS)) u_tcw_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for text_console_writer: random and directed print/read items,
// checked against an in-bench model of the screen store and cursor.
// Depends on tcw_pkg and text_console_writer.
module tb_top;

    import tcw_pkg::*;

    localparam int COLS       = DEF_COLS;
    localparam int ROWS       = DEF_ROWS;
    localparam int CELLS      = ROWS * COLS;
    localparam int N_ITEMS    = 1900;
    // the clearing pass and the scroll walk both stall input while they walk all cells
    localparam int STALL_LIMIT = 4 * (CELLS + 1) + 1000;

    localparam logic [CELL_W-1:0] BLANK = {ATTR, CH_SPACE};

    typedef struct {
        logic              cmd;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rrow;
        logic [COL_W-1:0]  rcol;
    } console_item_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_val;
        logic [POS_W-1:0]  pos;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } console_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic [S_USER_W-1:0]  s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;

    text_console_writer #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    console_item_t   pending_q[$];
    console_result_t expected_q[$];
    console_item_t   cur_item;

    // screen model
    logic [CELL_W-1:0] screen_mdl[CELLS];
    int cur_row = 0;
    int cur_col = 0;

    int n_total     = 0;
    int n_sent      = 0;
    int n_results   = 0;
    int n_errors    = 0;
    int n_prints    = 0;
    int n_reads     = 0;
    int n_oor_reads = 0;
    int n_scrolls   = 0;
    int n_wraps     = 0;
    int idle_cycles = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h", n_results, what, got, want);
        n_errors++;
    endtask

    task automatic next_row();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLS; i++)
                screen_mdl[i] = screen_mdl[i + COLS];
            for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
                screen_mdl[i] = BLANK;
            cur_row = ROWS - 1;
            n_scrolls++;
        end
    endtask

    task automatic console_predict(input console_item_t it, output console_result_t res);
        int linear;
        res = '0;
        if (it.cmd == CMD_PRINT) begin
            n_prints++;
            if (it.ch == CH_NEWLINE) begin
                next_row();
            end else if (it.ch == CH_RETURN) begin
                cur_col = 0;
            end else if (it.ch != CH_NULL) begin
                screen_mdl[cur_row * COLS + cur_col] = {ATTR, it.ch};
                cur_col++;
                if (cur_col >= COLS) begin
                    n_wraps++;
                    next_row();
                end
            end
        end else begin
            n_reads++;
            if (int'(it.rrow) < ROWS && int'(it.rcol) < COLS)
                res.cell_val = screen_mdl[int'(it.rrow) * COLS + int'(it.rcol)];
            else
                n_oor_reads++;
        end
        linear  = cur_row * COLS + cur_col;
        res.row = cur_row[ROW_W-1:0];
        res.col = cur_col[COL_W-1:0];
        res.pos = linear[POS_W-1:0];
    endtask

    // sender idles in 9% then 73% of cycles, receiver the other way round, then neither
    function automatic int idle_pct(input int done, input bit receiver);
        int phase;
        phase = (n_total == 0) ? 2 : (done * 3) / n_total;
        if (phase == 0) return receiver ? 73 : 9;
        if (phase == 1) return receiver ? 9 : 73;
        return 0;
    endfunction

    task automatic push_print(input logic [CHAR_W-1:0] ch);
        console_item_t it;
        it.cmd  = CMD_PRINT;
        it.ch   = ch;
        it.rrow = ROW_W'($urandom_range(0, 31));
        it.rcol = COL_W'($urandom_range(0, 127));
        pending_q.push_back(it);
    endtask

    task automatic push_read(input int row, input int col);
        console_item_t it;
        it.cmd  = CMD_READ;
        it.ch   = CHAR_W'($urandom_range(0, 255));
        it.rrow = ROW_W'(row);
        it.rcol = COL_W'(col);
        pending_q.push_back(it);
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return CH_NULL;
        if (r < 13) return CHAR_W'($urandom_range(0, 255));
        return CHAR_W'($urandom_range(8'h21, 8'h7e));
    endfunction

    // driver
    always @(posedge aclk) begin
        console_result_t res;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                console_predict(cur_item, res);
                expected_q.push_back(res);
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct(n_sent, 1'b0)) begin
                    cur_item = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, cur_item.rcol, cur_item.rrow, cur_item.ch};
                    s_tuser  <= cur_item.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        console_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing expected", m_tdata, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata[4:0] !== want.row)
                        report_mismatch("cursor_row", m_tdata[4:0], want.row);
                    if (m_tdata[11:5] !== want.col)
                        report_mismatch("cursor_col", m_tdata[11:5], want.col);
                    if (m_tdata[22:12] !== want.pos)
                        report_mismatch("cursor_position", m_tdata[22:12], want.pos);
                    if (m_tdata[38:23] !== want.cell_val)
                        report_mismatch("cell_value", m_tdata[38:23], want.cell_val);
                end
                n_results++;
            end
            m_tready <= ($urandom_range(0, 99) >= idle_pct(n_results, 1'b1));
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", idle_cycles);
                $display("simulation failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int kind;
        int len;
        int r;
        int n;

        for (int i = 0; i < CELLS; i++)
            screen_mdl[i] = BLANK;

        // directed: blank read, null, high-bit chars, CR, LF, range edges of reads
        push_read(0, 0);
        push_print(8'h48);
        push_print(CH_NULL);
        push_print(8'hff);
        push_print(8'h80);
        push_read(0, 0);
        push_read(0, 1);
        push_read(0, 3);
        push_print(CH_RETURN);
        push_print(8'h01);
        push_read(0, 0);
        push_print(CH_NEWLINE);
        push_read(31, 127);
        push_read(ROWS, 0);
        push_read(0, COLS);
        push_read(ROWS - 1, COLS - 1);
        push_print(8'h41);
        push_read(1, 0);
        push_print(CH_NEWLINE);
        push_print(CH_RETURN);
        push_read(1, 1);

        // random: text lines with terminators, read bursts, some noise
        while (pending_q.size() < N_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                len = ($urandom_range(0, 99) < 15) ? $urandom_range(60, 100)
                                                   : $urandom_range(0, 20);
                for (int i = 0; i < len; i++)
                    push_print(pick_char());
                r = $urandom_range(0, 99);
                if (r < 70)
                    push_print(CH_NEWLINE);
                else if (r < 85)
                    push_print(CH_RETURN);
            end else if (kind < 95) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        push_read(ROWS - 1, $urandom_range(0, COLS - 1));
                    else if (r < 85)
                        push_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
                    else if (r < 92)
                        push_read($urandom_range(ROWS, 31), $urandom_range(0, 127));
                    else
                        push_read($urandom_range(0, 31), $urandom_range(COLS, 127));
                end
            end else begin
                if ($urandom_range(0, 1))
                    push_print(CHAR_W'($urandom_range(0, 255)));
                else
                    push_read($urandom_range(0, 31), $urandom_range(0, 127));
            end
        end
        n_total = pending_q.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() > 0 || s_tvalid)
            @(posedge aclk);
        while (expected_q.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d prints and %0d reads (%0d out of range), %0d results",
                 n_prints, n_reads, n_oor_reads, n_results);
        $display("cursor wrapped %0d times, screen scrolled %0d times", n_wraps, n_scrolls);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/tcw_pkg.sv
hdl/text_console_writer.sv
hdl/tcw_checker.sv
tb/sv/tb_top.sv
